// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of the project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is high.
`define PSD_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define PSD_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

// ===== design/psd_pkg.sv =====
// Package of the program stream byte demux: word types, class codes and
// parser phase codes. No dependencies.
`default_nettype none

package psd_pkg;

  localparam int PSD_PROGRAM_COUNT_BITS = 8;

  // byte classes
  localparam logic [3:0] CLS_HUNT        = 4'd0;
  localparam logic [3:0] CLS_HEADER      = 4'd1;
  localparam logic [3:0] CLS_PSM         = 4'd2;
  localparam logic [3:0] CLS_ECM         = 4'd3;
  localparam logic [3:0] CLS_INDEX       = 4'd4;
  localparam logic [3:0] CLS_ELEMENTARY  = 4'd5;
  localparam logic [3:0] CLS_METADATA    = 4'd6;
  localparam logic [3:0] CLS_PADDING     = 4'd7;
  localparam logic [3:0] CLS_PROGRAM_END = 4'd8;

  // start code values and stream ids
  localparam logic [7:0] SC_PACK        = 8'hBA;
  localparam logic [7:0] SC_SYSTEM      = 8'hBB;
  localparam logic [7:0] SC_PROGRAM_END = 8'hB9;
  localparam logic [7:0] SID_PSM        = 8'hBC;
  localparam logic [7:0] SID_PADDING    = 8'hBE;
  localparam logic [7:0] SID_INDEX      = 8'hBF;
  localparam logic [7:0] SID_ECM        = 8'hF0;
  localparam logic [7:0] SID_METADATA   = 8'hF1;
  localparam logic [7:0] SID_NOEXT_F2   = 8'hF2;
  localparam logic [7:0] SID_NOEXT_F8   = 8'hF8;
  localparam logic [7:0] SID_NOEXT_FF   = 8'hFF;

  localparam logic [7:0] STUFF_MASK = 8'h07;
  localparam logic [7:0] TS_MASK0   = 8'h0E;
  localparam int         PTS_BIT    = 7;   // 0x80 of second flag byte
  localparam int         DTS_BIT    = 6;   // 0x40 of second flag byte

  // parser phases
  localparam logic [5:0] PH_SC1      = 6'd0;
  localparam logic [5:0] PH_SC2      = 6'd1;
  localparam logic [5:0] PH_SC3      = 6'd2;
  localparam logic [5:0] PH_SC4      = 6'd3;
  localparam logic [5:0] PH_PACK1    = 6'd4;
  localparam logic [5:0] PH_PACK10   = 6'd13;
  localparam logic [5:0] PH_STUFF    = 6'd14;
  localparam logic [5:0] PH_SYS1     = 6'd15;
  localparam logic [5:0] PH_SYS2     = 6'd16;
  localparam logic [5:0] PH_SYSSKIP  = 6'd17;
  localparam logic [5:0] PH_LEN1     = 6'd18;
  localparam logic [5:0] PH_LEN2     = 6'd19;
  localparam logic [5:0] PH_EXT1     = 6'd20;
  localparam logic [5:0] PH_EXT2     = 6'd21;
  localparam logic [5:0] PH_EXT3     = 6'd22;
  localparam logic [5:0] PH_PTS1     = 6'd23;
  localparam logic [5:0] PH_PTS2     = 6'd24;
  localparam logic [5:0] PH_PTS3     = 6'd25;
  localparam logic [5:0] PH_PTS4     = 6'd26;
  localparam logic [5:0] PH_PTS5     = 6'd27;
  localparam logic [5:0] PH_DTS1     = 6'd28;
  localparam logic [5:0] PH_DTS2     = 6'd29;
  localparam logic [5:0] PH_DTS3     = 6'd30;
  localparam logic [5:0] PH_DTS4     = 6'd31;
  localparam logic [5:0] PH_DTS5     = 6'd32;
  localparam logic [5:0] PH_HDR      = 6'd33;
  localparam logic [5:0] PH_DISPATCH = 6'd34;
  localparam logic [5:0] PH_PSM      = 6'd35;
  localparam logic [5:0] PH_ECM      = 6'd36;
  localparam logic [5:0] PH_INDEX    = 6'd37;
  localparam logic [5:0] PH_ES_FIRST = 6'd38;
  localparam logic [5:0] PH_ES       = 6'd39;
  localparam logic [5:0] PH_PAD      = 6'd40;

  typedef struct packed {
    logic [7:0] stream_byte;
  } byte_word_t;

  typedef struct packed {
    logic [3:0]  byte_class;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_stream_id;
    logic        packet_last;
    logic        sample_start;
    logic [32:0] presentation_time;
    logic [32:0] decode_time;
    logic        key_frame;
    logic        scrambled;
    logic        metadata_done;
    logic [7:0]  program_number;
  } result_word_t;

endpackage

`default_nettype wire

// ===== design/psd_stream_if.sv =====
// Valid/ready stream channel carrying one word per handshake.
// Depends on nothing; the word type is a parameter.
`default_nettype none

interface psd_stream_if #(parameter type word_t = logic [7:0]);
  logic  valid;
  logic  ready;
  word_t word;

  modport source (output valid, output word, input ready);
  modport sink   (input valid, input word, output ready);
endinterface

`default_nettype wire

// ===== design/program_stream_byte_demux.sv =====
// Program stream byte demux: top level. Uses psd_pkg and psd_stream_if.
// Parses a program stream one byte per word and classifies every byte.
//
// One byte in, one result out, one word per clock sustained. A byte is taken
// whenever the result register is empty or its word is being taken in the
// same cycle, so a full-rate stream flows with no bubbles; the result of a
// byte shows in the cycle after it is accepted. The parser state (phase,
// counters, flag bytes, timestamp shift register) is updated in the same
// edge that loads the result register, so the per-byte path is: resolve any
// zero-length skip, header or payload phase to the phase that really owns
// the byte, then execute that phase. Results carry the byte class (hunt,
// header, psm, ecm, index, elementary, metadata, padding, program end), the
// byte itself for payload classes, the current stream id, last-byte and
// sample-start marks, the latest PTS/DTS (DTS follows PTS when absent), the
// key-frame and scrambling bits of the first PES flag byte, the metadata
// done flag and a wrapping program counter. No configuration registers.
`default_nettype none

module program_stream_byte_demux
  import psd_pkg::*;
#(
  parameter int PROGRAM_COUNT_BITS = PSD_PROGRAM_COUNT_BITS
) (
  input  wire logic          clk,
  input  wire logic          rst,
  psd_stream_if.sink         byte_in,
  psd_stream_if.source       result_out
);

  localparam int PnBits = (PROGRAM_COUNT_BITS < 8) ? PROGRAM_COUNT_BITS : 8;

  // parser state
  logic [5:0]                    phase;
  logic [15:0]                   skip_remaining;
  logic [15:0]                   packet_remaining;
  logic [7:0]                    header_remaining;
  logic [7:0]                    current_stream;
  logic [7:0]                    flag_byte_one;
  logic [7:0]                    flag_byte_two;
  logic [32:0]                   time_shift;
  logic [32:0]                   pts_hold;
  logic [32:0]                   dts_hold;
  logic                          metadata_seen;
  logic [PROGRAM_COUNT_BITS-1:0] program_count;

  logic [5:0]                    phase_next;
  logic [15:0]                   skip_remaining_next;
  logic [15:0]                   packet_remaining_next;
  logic [7:0]                    header_remaining_next;
  logic [7:0]                    current_stream_next;
  logic [7:0]                    flag_byte_one_next;
  logic [7:0]                    flag_byte_two_next;
  logic [32:0]                   time_shift_next;
  logic [32:0]                   pts_hold_next;
  logic [32:0]                   dts_hold_next;
  logic                          metadata_seen_next;
  logic [PROGRAM_COUNT_BITS-1:0] program_count_next;

  // result register
  logic         out_valid;
  result_word_t out_word;
  result_word_t out_word_next;

  logic       accept;
  logic [7:0] b;
  logic [5:0] ph;          // phase that really handles this byte
  logic [3:0] cls;
  logic       last;
  logic       start;

  // Take a new byte when the result register is free or draining now.
  assign byte_in.ready    = !out_valid || result_out.ready;
  assign accept           = byte_in.valid && byte_in.ready;
  assign b                = byte_in.word.stream_byte;
  assign result_out.valid = out_valid;
  assign result_out.word  = out_word;

  // Resolve fall-through phases: zero-length skips, headers and payloads
  // hand the byte on without consuming it.
  always_comb begin
    ph = phase;
    if (ph > PH_PAD) begin
      ph = PH_SC1;
    end
    if ((ph == PH_STUFF || ph == PH_SYSSKIP) && skip_remaining == 16'd0) begin
      ph = PH_SC1;
    end
    if (ph == PH_HDR && header_remaining == 8'd0) begin
      ph = PH_DISPATCH;
    end
    if (ph == PH_DISPATCH) begin
      priority if (current_stream == SID_PSM)     ph = PH_PSM;
      else if (current_stream == SID_PADDING)     ph = PH_PAD;
      else if (current_stream == SID_ECM)         ph = PH_ECM;
      else if (current_stream == SID_INDEX)       ph = PH_INDEX;
      else                                        ph = PH_ES_FIRST;
    end
    if (ph >= PH_PSM && ph <= PH_PAD && packet_remaining == 16'd0) begin
      ph = PH_SC1;
    end
  end

  // Execute the resolved phase on the byte.
  always_comb begin
    phase_next            = ph;
    skip_remaining_next   = skip_remaining;
    packet_remaining_next = packet_remaining;
    header_remaining_next = header_remaining;
    current_stream_next   = current_stream;
    flag_byte_one_next    = flag_byte_one;
    flag_byte_two_next    = flag_byte_two;
    time_shift_next       = time_shift;
    pts_hold_next         = pts_hold;
    dts_hold_next         = dts_hold;
    metadata_seen_next    = metadata_seen;
    program_count_next    = program_count;
    cls                   = CLS_HEADER;
    last                  = 1'b0;
    start                 = 1'b0;

    if (ph >= PH_PACK1 && ph < PH_PACK10) begin
      // fixed pack header bytes: advance only
      phase_next = ph + 6'd1;
    end else if (ph >= PH_PTS1 && ph <= PH_DTS5) begin
      unique case (ph)
        PH_PTS1, PH_DTS1: time_shift_next = 33'(b & TS_MASK0);
        PH_PTS2, PH_DTS2: time_shift_next = (time_shift << 7) | 33'(b);
        PH_PTS3, PH_DTS3: time_shift_next = (time_shift << 7) | 33'(b >> 1);
        PH_PTS4, PH_DTS4: time_shift_next = (time_shift << 8) | 33'(b);
        default:          time_shift_next = (time_shift << 7) | 33'(b >> 1);
      endcase
      if (header_remaining != 8'd0) header_remaining_next = header_remaining - 8'd1;
      if (packet_remaining != 16'd0) packet_remaining_next = packet_remaining - 16'd1;
      if (ph == PH_PTS5) begin
        pts_hold_next = time_shift_next;
        if (flag_byte_two[DTS_BIT]) begin
          phase_next = PH_DTS1;
        end else begin
          dts_hold_next = time_shift_next;
          phase_next    = PH_HDR;
        end
      end else if (ph == PH_DTS5) begin
        dts_hold_next = time_shift_next;
        phase_next    = PH_HDR;
      end else begin
        phase_next = ph + 6'd1;
      end
    end else if (ph >= PH_PSM && ph <= PH_PAD) begin
      // payload byte; packet_remaining is nonzero here
      unique case (ph)
        PH_PSM:   cls = CLS_PSM;
        PH_ECM:   cls = CLS_ECM;
        PH_INDEX: cls = CLS_INDEX;
        PH_PAD:   cls = CLS_PADDING;
        default:  cls = (current_stream == SID_METADATA) ? CLS_METADATA
                                                         : CLS_ELEMENTARY;
      endcase
      if (ph == PH_ES_FIRST) begin
        start      = (cls == CLS_ELEMENTARY) && flag_byte_two[PTS_BIT];
        phase_next = PH_ES;
      end
      packet_remaining_next = packet_remaining - 16'd1;
      if (packet_remaining_next == 16'd0) begin
        last       = 1'b1;
        phase_next = PH_SC1;
      end
    end else begin
      unique case (ph)
        PH_SC1: begin
          cls = CLS_HUNT;
          if (b == 8'h00) phase_next = PH_SC2;
        end
        PH_SC2: begin
          cls        = CLS_HUNT;
          phase_next = (b == 8'h00) ? PH_SC3 : PH_SC1;
        end
        PH_SC3: begin
          cls = CLS_HUNT;
          if (b == 8'h01) phase_next = PH_SC4;
          else if (b != 8'h00) phase_next = PH_SC1;
        end
        PH_SC4: begin
          priority if (b == SC_PACK) begin
            phase_next = PH_PACK1;
          end else if (b == SC_SYSTEM) begin
            phase_next = PH_SYS1;
          end else if (b == SC_PROGRAM_END) begin
            cls                = CLS_PROGRAM_END;
            metadata_seen_next = 1'b1;
            pts_hold_next      = '0;
            dts_hold_next      = '0;
            program_count_next = program_count + PROGRAM_COUNT_BITS'(1);
            phase_next         = PH_SC1;
          end else begin
            current_stream_next = b;
            if (b != SID_PSM && b != SID_INDEX && b != SID_ECM &&
                b != SID_METADATA && b != SID_PADDING) begin
              metadata_seen_next = 1'b1;
            end
            phase_next = PH_LEN1;
          end
        end
        PH_PACK10: begin
          skip_remaining_next = 16'(b & STUFF_MASK);
          phase_next          = PH_STUFF;
        end
        PH_SYS1: begin
          skip_remaining_next = {b, 8'h00};
          phase_next          = PH_SYS2;
        end
        PH_SYS2: begin
          skip_remaining_next = {skip_remaining[15:8], b};
          phase_next          = PH_SYSSKIP;
        end
        PH_STUFF, PH_SYSSKIP: begin
          // skip_remaining is nonzero here
          skip_remaining_next = skip_remaining - 16'd1;
          if (skip_remaining_next == 16'd0) phase_next = PH_SC1;
        end
        PH_LEN1: begin
          packet_remaining_next = {b, 8'h00};
          phase_next            = PH_LEN2;
        end
        PH_LEN2: begin
          packet_remaining_next = {packet_remaining[15:8], b};
          if (current_stream != SID_PSM && current_stream != SID_PADDING &&
              current_stream != SID_INDEX && current_stream != SID_ECM &&
              current_stream != SID_NOEXT_F2 && current_stream != SID_NOEXT_F8 &&
              current_stream != SID_NOEXT_FF) begin
            phase_next = PH_EXT1;
          end else begin
            flag_byte_one_next    = '0;
            flag_byte_two_next    = '0;
            header_remaining_next = '0;
            phase_next            = PH_DISPATCH;
          end
        end
        PH_EXT1: begin
          flag_byte_one_next = b;
          if (packet_remaining != 16'd0) packet_remaining_next = packet_remaining - 16'd1;
          phase_next = PH_EXT2;
        end
        PH_EXT2: begin
          flag_byte_two_next = b;
          if (packet_remaining != 16'd0) packet_remaining_next = packet_remaining - 16'd1;
          phase_next = PH_EXT3;
        end
        PH_EXT3: begin
          header_remaining_next = b;
          if (packet_remaining != 16'd0) packet_remaining_next = packet_remaining - 16'd1;
          phase_next = flag_byte_two[PTS_BIT] ? PH_PTS1 : PH_HDR;
        end
        PH_HDR: begin
          // header_remaining is nonzero here
          header_remaining_next = header_remaining - 8'd1;
          if (packet_remaining != 16'd0) packet_remaining_next = packet_remaining - 16'd1;
          if (header_remaining_next == 8'd0) phase_next = PH_DISPATCH;
        end
        default: begin
          phase_next = PH_SC1;
        end
      endcase
    end
  end

  // Build the result word from the state after this byte.
  always_comb begin
    out_word_next.byte_class        = cls;
    out_word_next.payload_byte      = (cls >= CLS_PSM && cls <= CLS_PADDING) ? b : 8'h00;
    out_word_next.packet_stream_id  = current_stream_next;
    out_word_next.packet_last       = last;
    out_word_next.sample_start      = start;
    out_word_next.presentation_time = pts_hold_next;
    out_word_next.decode_time       = dts_hold_next;
    out_word_next.key_frame         = flag_byte_one_next[2];
    out_word_next.scrambled         = |flag_byte_one_next[5:4];
    out_word_next.metadata_done     = metadata_seen_next;
    out_word_next.program_number    = 8'(program_count_next[PnBits-1:0]);
  end

  // Parser state: advance once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_SC1;
      skip_remaining   <= '0;
      packet_remaining <= '0;
      header_remaining <= '0;
      current_stream   <= '0;
      flag_byte_one    <= '0;
      flag_byte_two    <= '0;
      time_shift       <= '0;
      pts_hold         <= '0;
      dts_hold         <= '0;
      metadata_seen    <= 1'b0;
      program_count    <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      skip_remaining   <= skip_remaining_next;
      packet_remaining <= packet_remaining_next;
      header_remaining <= header_remaining_next;
      current_stream   <= current_stream_next;
      flag_byte_one    <= flag_byte_one_next;
      flag_byte_two    <= flag_byte_two_next;
      time_shift       <= time_shift_next;
      pts_hold         <= pts_hold_next;
      dts_hold         <= dts_hold_next;
      metadata_seen    <= metadata_seen_next;
      program_count    <= program_count_next;
    end
  end

  // Result register: load on accept, drop when taken, hold otherwise.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word <= out_word_next;
    end
  end

endmodule

`default_nettype wire

// ===== design/psd_checker.sv =====
// Port-level checker for the program stream byte demux, bound to the top.
// Uses psd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module psd_checker
  import psd_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         out_valid,
  input wire logic         out_ready,
  input wire result_word_t out_word
);

  // a stalled result holds its word
  `PSD_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_word))

  // sample start only on an elementary byte
  `PSD_ASSERT(a_start_es, clk, rst, out_valid && out_word.sample_start |-> out_word.byte_class == CLS_ELEMENTARY)

  // last mark only on payload classes
  `PSD_ASSERT(a_last_payload, clk, rst, out_valid && out_word.packet_last |-> out_word.byte_class == CLS_PSM || out_word.byte_class == CLS_ECM || out_word.byte_class == CLS_INDEX || out_word.byte_class == CLS_ELEMENTARY || out_word.byte_class == CLS_METADATA || out_word.byte_class == CLS_PADDING)

  // program end clears both timestamps and marks metadata done
  `PSD_ASSERT(a_prog_end, clk, rst, out_valid && out_word.byte_class == CLS_PROGRAM_END |-> out_word.presentation_time == '0 && out_word.decode_time == '0 && out_word.metadata_done)

  // no result word right after reset
  `PSD_ASSERT_ALWAYS(a_reset_empty, clk, $past(rst) |-> !out_valid)

endmodule

bind program_stream_byte_demux psd_checker u_psd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (result_out.valid),
  .out_ready (result_out.ready),
  .out_word  (result_out.word)
);

`default_nettype wire

// ===== test/tb.sv =====
// Self-checking testbench for program_stream_byte_demux: a byte-level parser
// model in a scoreboard class predicts every result word. Depends on psd_pkg,
// psd_stream_if and the block itself.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import psd_pkg::*;

  // Start code prefix bytes and a few ordinary PES stream ids.
  localparam logic [7:0] PFX_ZERO    = 8'h00;
  localparam logic [7:0] PFX_ONE     = 8'h01;
  localparam logic [7:0] SID_VIDEO   = 8'hE0;
  localparam logic [7:0] SID_AUDIO   = 8'hC0;
  localparam logic [7:0] SID_PRIVATE = 8'hBD;
  localparam logic [7:0] FILL_BYTE   = 8'hFF;

  localparam int RANDOM_BYTES = 1950;
  localparam int SETTLE_CYCLES = 16;

  // Scoreboard: tracks the parser state byte by byte, keeps the expected
  // result words in arrival order and compares them with what comes out.
  class stream_parse_checker;
    logic [5:0]  phase;
    logic [15:0] skip_left;
    logic [15:0] pkt_left;
    logic [7:0]  hdr_left;
    logic [7:0]  sid;
    logic [7:0]  flags1;
    logic [7:0]  flags2;
    logic [32:0] ts_acc;
    logic [32:0] pts;
    logic [32:0] dts;
    logic        meta_flag;
    logic [7:0]  prog_cnt;

    result_word_t expected_results[$];
    int errors;
    int bytes_seen;
    int words_checked;
    int class_hist[9];
    int samples;

    function new();
      phase = PH_SC1;
      skip_left = '0;
      pkt_left = '0;
      hdr_left = '0;
      sid = '0;
      flags1 = '0;
      flags2 = '0;
      ts_acc = '0;
      pts = '0;
      dts = '0;
      meta_flag = 1'b0;
      prog_cnt = '0;
      errors = 0;
      bytes_seen = 0;
      words_checked = 0;
      samples = 0;
      foreach (class_hist[i]) class_hist[i] = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void take_packet_byte();
      if (pkt_left != 0) pkt_left--;
    endfunction

    function void take_header_byte();
      if (hdr_left != 0) hdr_left--;
      take_packet_byte();
    endfunction

    // Advance the parser by one accepted byte and queue the word it yields.
    function void note_byte(logic [7:0] b);
      logic [3:0] cls;
      logic       is_last;
      logic       starts_sample;
      bit         done;
      logic [5:0] ph;
      int         k;
      int         guard;
      result_word_t w;

      cls = CLS_HEADER;
      is_last = 1'b0;
      starts_sample = 1'b0;
      done = 1'b0;
      // A zero-count phase hands the same byte on, so loop until one owns it.
      for (guard = 0; guard < 8 && !done; guard++) begin
        ph = phase;
        done = 1'b1;
        if (ph >= PH_PACK1 && ph < PH_PACK10) begin
          phase = ph + 6'd1;
        end else if (ph >= PH_PTS1 && ph <= PH_DTS5) begin
          k = (ph - PH_PTS1) % 5;
          case (k)
            0: ts_acc = 33'(b & TS_MASK0);
            1: ts_acc = (ts_acc << 7) | 33'(b);
            2: ts_acc = (ts_acc << 7) | 33'(b >> 1);
            3: ts_acc = (ts_acc << 8) | 33'(b);
            default: ts_acc = (ts_acc << 7) | 33'(b >> 1);
          endcase
          take_header_byte();
          if (ph == PH_PTS5) begin
            pts = ts_acc;
            if (flags2[DTS_BIT]) begin
              phase = PH_DTS1;
            end else begin
              dts = pts;
              phase = PH_HDR;
            end
          end else if (ph == PH_DTS5) begin
            dts = ts_acc;
            phase = PH_HDR;
          end else begin
            phase = ph + 6'd1;
          end
        end else if (ph == PH_SC1) begin
          cls = CLS_HUNT;
          if (b == PFX_ZERO) phase = PH_SC2;
        end else if (ph == PH_SC2) begin
          cls = CLS_HUNT;
          phase = (b == PFX_ZERO) ? PH_SC3 : PH_SC1;
        end else if (ph == PH_SC3) begin
          cls = CLS_HUNT;
          if (b == PFX_ONE) phase = PH_SC4;
          else if (b != PFX_ZERO) phase = PH_SC1;
        end else if (ph == PH_SC4) begin
          if (b == SC_PACK) begin
            phase = PH_PACK1;
          end else if (b == SC_SYSTEM) begin
            phase = PH_SYS1;
          end else if (b == SC_PROGRAM_END) begin
            cls = CLS_PROGRAM_END;
            meta_flag = 1'b1;
            pts = '0;
            dts = '0;
            prog_cnt++;
            phase = PH_SC1;
          end else begin
            sid = b;
            if (!(b inside {SID_PSM, SID_INDEX, SID_ECM, SID_METADATA, SID_PADDING}))
              meta_flag = 1'b1;
            phase = PH_LEN1;
          end
        end else if (ph == PH_PACK10) begin
          skip_left = 16'(b & STUFF_MASK);
          phase = PH_STUFF;
        end else if (ph == PH_SYS1) begin
          skip_left = {b, 8'h00};
          phase = PH_SYS2;
        end else if (ph == PH_SYS2) begin
          skip_left = skip_left | 16'(b);
          phase = PH_SYSSKIP;
        end else if (ph == PH_STUFF || ph == PH_SYSSKIP) begin
          if (skip_left == 0) begin
            phase = PH_SC1;
            done = 1'b0;
          end else begin
            skip_left--;
            if (skip_left == 0) phase = PH_SC1;
          end
        end else if (ph == PH_LEN1) begin
          pkt_left = {b, 8'h00};
          phase = PH_LEN2;
        end else if (ph == PH_LEN2) begin
          pkt_left = pkt_left | 16'(b);
          if (sid inside {SID_PSM, SID_PADDING, SID_INDEX, SID_ECM, SID_NOEXT_F2,
                          SID_NOEXT_F8, SID_NOEXT_FF}) begin
            flags1 = '0;
            flags2 = '0;
            hdr_left = '0;
            phase = PH_DISPATCH;
          end else begin
            phase = PH_EXT1;
          end
        end else if (ph == PH_EXT1) begin
          flags1 = b;
          take_packet_byte();
          phase = PH_EXT2;
        end else if (ph == PH_EXT2) begin
          flags2 = b;
          take_packet_byte();
          phase = PH_EXT3;
        end else if (ph == PH_EXT3) begin
          hdr_left = b;
          take_packet_byte();
          phase = flags2[PTS_BIT] ? PH_PTS1 : PH_HDR;
        end else if (ph == PH_HDR) begin
          if (hdr_left == 0) begin
            phase = PH_DISPATCH;
            done = 1'b0;
          end else begin
            take_header_byte();
            if (hdr_left == 0) phase = PH_DISPATCH;
          end
        end else if (ph == PH_DISPATCH) begin
          if (sid == SID_PSM) phase = PH_PSM;
          else if (sid == SID_PADDING) phase = PH_PAD;
          else if (sid == SID_ECM) phase = PH_ECM;
          else if (sid == SID_INDEX) phase = PH_INDEX;
          else phase = PH_ES_FIRST;
          done = 1'b0;
        end else if (ph >= PH_PSM && ph <= PH_PAD) begin
          if (pkt_left == 0) begin
            phase = PH_SC1;
            done = 1'b0;
          end else begin
            if (ph == PH_PSM) cls = CLS_PSM;
            else if (ph == PH_ECM) cls = CLS_ECM;
            else if (ph == PH_INDEX) cls = CLS_INDEX;
            else if (ph == PH_PAD) cls = CLS_PADDING;
            else cls = (sid == SID_METADATA) ? CLS_METADATA : CLS_ELEMENTARY;
            if (ph == PH_ES_FIRST) begin
              if (cls == CLS_ELEMENTARY && flags2[PTS_BIT]) starts_sample = 1'b1;
              phase = PH_ES;
            end
            pkt_left--;
            if (pkt_left == 0) begin
              is_last = 1'b1;
              phase = PH_SC1;
            end
          end
        end else begin
          phase = PH_SC1;
          done = 1'b0;
        end
      end

      w.byte_class        = cls;
      w.payload_byte      = (cls >= CLS_PSM && cls <= CLS_PADDING) ? b : 8'h00;
      w.packet_stream_id  = sid;
      w.packet_last       = is_last;
      w.sample_start      = starts_sample;
      w.presentation_time = pts;
      w.decode_time       = dts;
      w.key_frame         = flags1[2];
      w.scrambled         = |flags1[5:4];
      w.metadata_done     = meta_flag;
      w.program_number    = prog_cnt;
      expected_results.insert(expected_results.size(), w);
      bytes_seen++;
      class_hist[cls]++;
      if (starts_sample) samples++;
    endfunction

    function void report(string field, logic [32:0] want, logic [32:0] got);
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      errors++;
    endfunction

    // Compare one result word with the oldest expectation, field by field.
    function void check_result(result_word_t got);
      result_word_t want;
      if (expected_results.size() == 0) begin
        $error("result word with no byte waiting for it");
        errors++;
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      words_checked++;
      if (got.byte_class !== want.byte_class)
        report("byte_class", 33'(want.byte_class), 33'(got.byte_class));
      if (got.payload_byte !== want.payload_byte)
        report("payload_byte", 33'(want.payload_byte), 33'(got.payload_byte));
      if (got.packet_stream_id !== want.packet_stream_id)
        report("packet_stream_id", 33'(want.packet_stream_id), 33'(got.packet_stream_id));
      if (got.packet_last !== want.packet_last)
        report("packet_last", 33'(want.packet_last), 33'(got.packet_last));
      if (got.sample_start !== want.sample_start)
        report("sample_start", 33'(want.sample_start), 33'(got.sample_start));
      if (got.presentation_time !== want.presentation_time)
        report("presentation_time", want.presentation_time, got.presentation_time);
      if (got.decode_time !== want.decode_time)
        report("decode_time", want.decode_time, got.decode_time);
      if (got.key_frame !== want.key_frame)
        report("key_frame", 33'(want.key_frame), 33'(got.key_frame));
      if (got.scrambled !== want.scrambled)
        report("scrambled", 33'(want.scrambled), 33'(got.scrambled));
      if (got.metadata_done !== want.metadata_done)
        report("metadata_done", 33'(want.metadata_done), 33'(got.metadata_done));
      if (got.program_number !== want.program_number)
        report("program_number", 33'(want.program_number), 33'(got.program_number));
    endfunction
  endclass

  logic clk;
  logic rst;

  psd_stream_if #(.word_t(byte_word_t))   byte_in ();
  psd_stream_if #(.word_t(result_word_t)) result_out ();

  program_stream_byte_demux DUT (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .result_out (result_out)
  );

  stream_parse_checker sb = new();

  // Bytes still to be sent, built up by the planning tasks below.
  logic [7:0] byte_plan[$];

  int rx_span;
  int rx_mode;
  logic [7:0] rx_pat;

  // Append one byte to the send plan.
  function automatic void plan_byte(logic [7:0] v);
    byte_plan.insert(byte_plan.size(), v);
  endfunction

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAIL program_stream_byte_demux");
    $finish;
  end

  // Monitor: note accepted bytes first, then check the result word taken at
  // the same edge. Values read here are the ones that stood before the edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (byte_in.valid && byte_in.ready) sb.note_byte(byte_in.word.stream_byte);
      if (result_out.valid && result_out.ready) sb.check_result(result_out.word);
    end
  end

  // Receiver: switch between always-ready, random stalls and a rotating
  // pattern, each for a random span of cycles.
  initial begin
    result_out.ready <= 1'b0;
    rx_span = 0;
    rx_pat = 8'b1101_0110;
    forever begin
      @(posedge clk);
      if (rx_span == 0) begin
        rx_mode = $urandom_range(0, 2);
        rx_span = $urandom_range(16, 160);
      end
      rx_span--;
      case (rx_mode)
        0: result_out.ready <= 1'b1;
        1: result_out.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          result_out.ready <= rx_pat[0];
          rx_pat = {rx_pat[0], rx_pat[7:1]};
        end
      endcase
    end
  end

  task automatic plan_start(logic [7:0] code);
    plan_byte(PFX_ZERO);
    plan_byte(PFX_ZERO);
    plan_byte(PFX_ONE);
    plan_byte(code);
  endtask

  // Pack header: nine fixed bytes, then the stuffing count and the stuffing.
  task automatic plan_pack();
    logic [7:0] stuff;
    plan_start(SC_PACK);
    repeat (9) plan_byte(8'($urandom));
    stuff = 8'($urandom);
    plan_byte(stuff);
    repeat (stuff & STUFF_MASK) plan_byte(FILL_BYTE);
  endtask

  // System header: mostly short, now and then long enough to use the high
  // length byte.
  task automatic plan_system();
    int n;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 12);
    plan_start(SC_SYSTEM);
    plan_byte(8'(n >> 8));
    plan_byte(8'(n));
    repeat (n) plan_byte(8'($urandom));
  endtask

  // PES packet with a random stream id, flags, timestamps and payload. A few
  // get a wrong packet length or a wrong header-data length.
  task automatic plan_pes();
    logic [7:0] id;
    logic [7:0] f1;
    logic [7:0] f2;
    logic [7:0] hl;
    int ts_n;
    int pad_n;
    int pay_n;
    int len;
    bit ext;
    case ($urandom_range(0, 13))
      0: id = SID_PSM;
      1: id = SID_PADDING;
      2: id = SID_INDEX;
      3: id = SID_ECM;
      4, 5: id = SID_METADATA;
      6: id = SID_NOEXT_F2;
      7: id = SID_NOEXT_F8;
      8: id = SID_NOEXT_FF;
      9, 10: id = SID_VIDEO;
      11: id = SID_AUDIO;
      12: id = SID_PRIVATE;
      default: id = 8'($urandom);
    endcase
    ext = !(id inside {SID_PSM, SID_PADDING, SID_INDEX, SID_ECM, SID_NOEXT_F2,
                       SID_NOEXT_F8, SID_NOEXT_FF});
    pay_n = ($urandom_range(0, 29) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 20);
    f1 = 8'($urandom);
    f2 = 8'($urandom);
    ts_n = f2[PTS_BIT] ? (f2[DTS_BIT] ? 10 : 5) : 0;
    pad_n = $urandom_range(0, 3);
    hl = 8'(ts_n + pad_n);
    if ($urandom_range(0, 9) == 0) hl = 8'($urandom);
    len = ext ? 3 + ts_n + pad_n + pay_n : pay_n;
    if ($urandom_range(0, 11) == 0) len = $urandom_range(0, len);
    plan_start(id);
    plan_byte(8'(len >> 8));
    plan_byte(8'(len));
    if (ext) begin
      plan_byte(f1);
      plan_byte(f2);
      plan_byte(hl);
      repeat (ts_n) plan_byte(8'($urandom));
      repeat (pad_n) plan_byte(FILL_BYTE);
    end
    repeat (pay_n) plan_byte(8'($urandom));
  endtask

  // Mostly well-formed sections; the rest is junk and broken prefixes.
  task automatic plan_random(int n);
    int pick;
    while (byte_plan.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        plan_pes();
      end else if (pick < 67) begin
        plan_pack();
      end else if (pick < 75) begin
        plan_system();
      end else if (pick < 83) begin
        plan_start(SC_PROGRAM_END);
      end else if (pick < 93) begin
        repeat ($urandom_range(1, 6))
          plan_byte(($urandom_range(0, 2) == 0) ? PFX_ZERO : 8'($urandom));
      end else begin
        plan_byte(PFX_ZERO);
        plan_byte(PFX_ZERO);
        plan_byte(8'($urandom_range(2, 255)));
      end
    end
  endtask

  // Send the planned bytes in bursts of random length with random gaps;
  // some bursts are long so that stretches run at full rate.
  task automatic send_plan();
    int burst;
    int gap;
    burst = 0;
    while (byte_plan.size() != 0) begin
      if (burst == 0) begin
        burst = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          byte_in.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      byte_in.valid <= 1'b1;
      byte_in.word.stream_byte <= byte_plan[0];
      byte_plan.delete(0);
      @(posedge clk);
      while (!byte_in.ready) @(posedge clk);
      burst--;
    end
    byte_in.valid <= 1'b0;
  endtask

  // Hold the sender until every expected word has come back.
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    rst <= 1'b1;
    byte_in.valid <= 1'b0;
    byte_in.word <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed bytes: a zero at the third hunt position before 01, program
    // end, a PSM packet of zero length (next byte falls back to hunting),
    // then a video packet whose length is shorter than its header so both
    // counters saturate, with key frame, scrambling and an all-ones PTS.
    byte_plan = '{PFX_ZERO, PFX_ZERO, PFX_ZERO, PFX_ONE, SC_PROGRAM_END,
                  PFX_ZERO, PFX_ZERO, PFX_ONE, SID_PSM, 8'h00, 8'h00,
                  PFX_ZERO, PFX_ZERO, PFX_ONE, SID_VIDEO, 8'h00, 8'h02,
                  8'hB4, 8'h80, 8'h00,
                  FILL_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE, FILL_BYTE};
    send_plan();
    wait_drained();

    // Random part in two halves with a full drain between them.
    plan_random(RANDOM_BYTES / 2);
    send_plan();
    wait_drained();
    plan_random(RANDOM_BYTES / 2);
    send_plan();

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Checked %0d result words for %0d bytes: %0d psm, %0d ecm, %0d index, %0d es,",
             sb.words_checked, sb.bytes_seen, sb.class_hist[CLS_PSM], sb.class_hist[CLS_ECM],
             sb.class_hist[CLS_INDEX], sb.class_hist[CLS_ELEMENTARY]);
    $display("  %0d metadata, %0d padding, %0d program ends, %0d samples, %0d mismatches",
             sb.class_hist[CLS_METADATA], sb.class_hist[CLS_PADDING],
             sb.class_hist[CLS_PROGRAM_END], sb.samples, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS program_stream_byte_demux");
    end else begin
      $display("FAIL program_stream_byte_demux");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/psd_pkg.sv
design/psd_stream_if.sv
design/program_stream_byte_demux.sv
design/psd_checker.sv
test/tb.sv
